// ----- hw/rtl/lscp_pkg.sv -----
// ----------------------------------------------------------------------------
// Line sensor calibration package
// Constants and helper functions shared by the line sensor position block.
// ----------------------------------------------------------------------------
package lscp_pkg;

	localparam int SENSORS_MAX = 10;
	localparam int SIDX_W      = (SENSORS_MAX > 1) ? $clog2(SENSORS_MAX) : 1;
	localparam int CNT_W       = 5;
	localparam int WSUM_W      = 33;
	localparam int VSUM_W      = 20;
	localparam int POS_W       = 14;
	localparam int PROD_W      = 30;
	localparam int DIV_STEPS   = WSUM_W;
	localparam int DCNT_W      = $clog2(DIV_STEPS + 1);

	localparam logic [15:0] LINE_LEVEL   = 16'd200;
	localparam logic [15:0] WEIGHT_LEVEL = 16'd50;
	localparam logic [15:0] SAT16        = 16'hFFFF;

	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_CAL    = 2'd1;
	localparam logic [1:0] FUNC_DETECT = 2'd2;

	typedef logic [15:0] sample_t;

	function automatic logic [POS_W-1:0] sensor_weight(input logic [3:0] idx);
		return POS_W'(idx * 1000);
	endfunction

	function automatic logic [POS_W-1:0] far_end(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] m;
		m = n - CNT_W'(1);
		return POS_W'(m * 1000);
	endfunction

endpackage

// ----- hw/rtl/line_sensor_calibrate_position_top.sv -----
// ----------------------------------------------------------------------------
// Line sensor calibration and position
// Tracks per-sensor reflectance windows, normalises readings with a shared
// restoring divider and derives the weighted line position at frame end.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  cfg      | in        | cfg_valid / cfg_ready  | cfg_data (sensor count)
//  in       | in        | in_valid / in_stall    | func, sensor_index, raw_value,
//           |           |                        | last_of_frame
//  out      | out       | out_valid / out_stall  | normalized_value, position,
//           |           |                        | position_valid, line_seen, status
//
// Error and clear transactions do not use the divider; a normalising division runs on
// the shared one-bit-per-cycle divider, and a reading that closes a frame may use it a
// second time for the position. A new transaction is taken only from idle.
// Reset clears all calibration windows and accumulators at once.
// A stalled result waits in the output register; the next transaction is taken meanwhile.
module line_sensor_calibrate_position_top
	import lscp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [3:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          func,
	input  logic [3:0]          sensor_index,
	input  logic [15:0]         raw_value,
	input  logic                last_of_frame,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [15:0]         normalized_value,
	output logic [POS_W-1:0]    position,
	output logic                position_valid,
	output logic                line_seen,
	output logic                status
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_NORM   = 4'd2;
	localparam logic [3:0] S_DIV    = 4'd3;
	localparam logic [3:0] S_NDONE  = 4'd4;
	localparam logic [3:0] S_ACC    = 4'd5;
	localparam logic [3:0] S_SUM    = 4'd6;
	localparam logic [3:0] S_POS    = 4'd7;
	localparam logic [3:0] S_PDONE  = 4'd8;
	localparam logic [3:0] S_CLOSE  = 4'd9;
	localparam logic [3:0] S_OUT    = 4'd10;

	logic [3:0]         state_q;
	logic [3:0]         cnt_cfg_q;
	sample_t            max_q [SENSORS_MAX];
	sample_t            min_q [SENSORS_MAX];
	logic [SENSORS_MAX-1:0] cal_q;
	logic [WSUM_W-1:0]  wsum_q;
	logic [VSUM_W-1:0]  vsum_q;
	logic               line_flag_q;
	logic [POS_W-1:0]   last_pos_q;

	logic [1:0]         func_q;
	logic [3:0]         idx_q;
	sample_t            raw_q;
	logic               last_q;
	sample_t            lo_q;
	sample_t            hi_q;
	logic               sel_cal_q;
	sample_t            norm_q;
	logic               status_q;
	logic               pvalid_q;
	logic               seen_q;
	logic               weigh_q;
	logic [PROD_W-1:0]  prod_q;

	logic [VSUM_W-1:0]  rem_q;
	logic [WSUM_W-1:0]  quo_q;
	logic [VSUM_W-1:0]  dvs_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic               div_pos_q;

	logic               ovalid_q;
	sample_t            onorm_q;
	logic [POS_W-1:0]   opos_q;
	logic               opvalid_q;
	logic               oseen_q;
	logic               ostatus_q;

	logic [CNT_W-1:0]   n_w;
	logic [SIDX_W-1:0]  sel_w;
	logic [POS_W-1:0]   far_w;
	logic [VSUM_W:0]    shifted_w;
	logic [VSUM_W:0]    trial_w;
	logic [VSUM_W:0]    vsum_add_w;
	logic [WSUM_W:0]    wsum_add_w;
	logic [25:0]        numer_w;
	logic               out_free_w;
	logic               accept_w;

	assign n_w = (cnt_cfg_q > CNT_W'(SENSORS_MAX)) ? CNT_W'(SENSORS_MAX)
		: CNT_W'(cnt_cfg_q);
	assign sel_w      = idx_q[SIDX_W-1:0];
	assign far_w      = far_end(n_w);
	assign shifted_w  = {rem_q, quo_q[WSUM_W-1]};
	assign trial_w    = shifted_w - {1'b0, dvs_q};
	assign vsum_add_w = {1'b0, vsum_q} + (VSUM_W+1)'(norm_q);
	assign wsum_add_w = {1'b0, wsum_q} + (WSUM_W+1)'(prod_q);
	assign numer_w    = 26'(raw_q - lo_q) * 26'd1000;
	assign out_free_w = !ovalid_q || !out_stall;
	assign accept_w   = in_valid && !in_stall;

	assign cfg_ready = (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);

	assign out_valid        = ovalid_q;
	assign normalized_value = onorm_q;
	assign position         = opos_q;
	assign position_valid   = opvalid_q;
	assign line_seen        = oseen_q;
	assign status           = ostatus_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_cfg_q   <= '0;
			cal_q       <= '0;
			wsum_q      <= '0;
			vsum_q      <= '0;
			line_flag_q <= 1'b0;
			last_pos_q  <= '0;
			ovalid_q    <= 1'b0;
			dcnt_q      <= '0;
			for (int i = 0; i < SENSORS_MAX; i++) begin
				max_q[i] <= '0;
				min_q[i] <= SAT16;
			end
		end else begin
			if (ovalid_q && !out_stall && state_q != S_OUT) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						cnt_cfg_q <= cfg_data;
					end
					if (accept_w) begin
						func_q   <= func;
						idx_q    <= sensor_index;
						raw_q    <= raw_value;
						last_q   <= last_of_frame;
						norm_q   <= '0;
						status_q <= 1'b0;
						pvalid_q <= 1'b0;
						seen_q   <= 1'b0;
						state_q  <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (n_w == '0 || (func_q != FUNC_CLEAR && func_q != FUNC_CAL
						&& func_q != FUNC_DETECT)) begin
						status_q <= 1'b1;
						state_q  <= S_OUT;
					end else if (func_q == FUNC_CLEAR) begin
						for (int i = 0; i < SENSORS_MAX; i++) begin
							if (CNT_W'(i) < n_w) begin
								max_q[i] <= '0;
								min_q[i] <= SAT16;
								cal_q[i] <= 1'b0;
							end
						end
						state_q <= S_OUT;
					end else if (CNT_W'(idx_q) >= n_w) begin
						status_q <= 1'b1;
						state_q  <= S_OUT;
					end else if (func_q == FUNC_CAL) begin
						hi_q         <= (max_q[sel_w] < raw_q) ? raw_q : max_q[sel_w];
						lo_q         <= (min_q[sel_w] > raw_q) ? raw_q : min_q[sel_w];
						max_q[sel_w] <= (max_q[sel_w] < raw_q) ? raw_q : max_q[sel_w];
						min_q[sel_w] <= (min_q[sel_w] > raw_q) ? raw_q : min_q[sel_w];
						cal_q[sel_w] <= 1'b1;
						sel_cal_q    <= 1'b1;
						state_q      <= S_NORM;
					end else begin
						hi_q      <= max_q[sel_w];
						lo_q      <= min_q[sel_w];
						sel_cal_q <= cal_q[sel_w];
						state_q   <= S_NORM;
					end
				end
				S_NORM: begin
					if (!sel_cal_q) begin
						norm_q  <= raw_q;
						state_q <= S_NDONE;
					end else if (raw_q < lo_q) begin
						norm_q  <= '0;
						state_q <= S_NDONE;
					end else if (hi_q <= lo_q) begin
						norm_q  <= SAT16;
						state_q <= S_NDONE;
					end else begin
						rem_q     <= '0;
						quo_q     <= WSUM_W'(numer_w);
						dvs_q     <= VSUM_W'(hi_q - lo_q);
						dcnt_q    <= DCNT_W'(DIV_STEPS);
						div_pos_q <= 1'b0;
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					if (!trial_w[VSUM_W]) begin
						rem_q <= trial_w[VSUM_W-1:0];
						quo_q <= {quo_q[WSUM_W-2:0], 1'b1};
					end else begin
						rem_q <= shifted_w[VSUM_W-1:0];
						quo_q <= {quo_q[WSUM_W-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q - DCNT_W'(1);
					if (dcnt_q == DCNT_W'(1)) begin
						state_q <= div_pos_q ? S_PDONE : S_NDONE;
					end else if (!div_pos_q && sel_cal_q && raw_q < lo_q) begin
						state_q <= S_NDONE;
					end
				end
				S_NDONE: begin
					if (sel_cal_q && raw_q >= lo_q && hi_q > lo_q) begin
						norm_q <= (|quo_q[WSUM_W-1:16]) ? SAT16 : quo_q[15:0];
					end
					state_q <= (func_q == FUNC_DETECT) ? S_ACC : S_OUT;
				end
				S_ACC: begin
					if (norm_q > LINE_LEVEL) begin
						line_flag_q <= 1'b1;
					end
					weigh_q <= (norm_q > WEIGHT_LEVEL);
					prod_q  <= PROD_W'(sensor_weight(idx_q) * norm_q);
					if (norm_q > WEIGHT_LEVEL) begin
						vsum_q <= vsum_add_w[VSUM_W] ? '1 : vsum_add_w[VSUM_W-1:0];
					end
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (weigh_q) begin
						wsum_q <= wsum_add_w[WSUM_W] ? '1 : wsum_add_w[WSUM_W-1:0];
					end
					state_q <= last_q ? S_POS : S_OUT;
				end
				S_POS: begin
					if (line_flag_q && vsum_q != '0) begin
						rem_q     <= '0;
						quo_q     <= wsum_q;
						dvs_q     <= vsum_q;
						dcnt_q    <= DCNT_W'(DIV_STEPS);
						div_pos_q <= 1'b1;
						state_q   <= S_DIV;
					end else begin
						last_pos_q <= (last_pos_q < (far_w >> 1)) ? '0 : far_w;
						state_q    <= S_CLOSE;
					end
				end
				S_PDONE: begin
					last_pos_q <= (quo_q > WSUM_W'(far_w)) ? far_w : quo_q[POS_W-1:0];
					state_q    <= S_CLOSE;
				end
				S_CLOSE: begin
					pvalid_q    <= 1'b1;
					seen_q      <= line_flag_q;
					wsum_q      <= '0;
					vsum_q      <= '0;
					line_flag_q <= 1'b0;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (out_free_w) begin
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free_w) begin
			onorm_q   <= norm_q;
			opos_q    <= last_pos_q;
			opvalid_q <= pvalid_q;
			oseen_q   <= seen_q;
			ostatus_q <= status_q;
		end
	end

	// An accepted transaction always keeps the input side busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept_w |=> in_stall)
		else $error("input not stalled after an accepted transaction");

	// A closed frame never carries an error.
	a_close_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(position_valid && status))
		else $error("frame closed on an erroneous transaction");

	// Erroneous transactions return a zero reading.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (normalized_value == '0))
		else $error("non-zero reading on an erroneous transaction");

	// The line mark is only reported on a closing transaction.
	a_seen_close: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && line_seen) |-> position_valid)
		else $error("line mark outside a frame close");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line sensor calibration and position testbench
// Drives reflectance readings through the block under varied sensor counts and
// handshake pressure, and checks every result against a cycle-free predictor of
// the calibration windows, normalisation and frame centroid (typed rows apart).
// ----------------------------------------------------------------------------
module tb
	import lscp_pkg::*;
;

	localparam logic [1:0]      FUNC_UNUSED = 2'd3;
	localparam logic            STATUS_OK   = 1'b0;
	localparam logic            STATUS_ERR  = 1'b1;
	localparam longint unsigned NORM_SCALE  = 1000;
	localparam longint unsigned WSUM_LIMIT  = (64'd1 << WSUM_W) - 64'd1;
	localparam longint unsigned VSUM_LIMIT  = (64'd1 << VSUM_W) - 64'd1;
	localparam int              CYCLE_LIMIT = 2000000;
	localparam int              DRAIN_PAUSE = 100;
	localparam int              MAX_REPORTS = 40;
	localparam int              PHASE_QUOTA = 125;

	typedef struct packed {
		logic [15:0]      norm;
		logic [POS_W-1:0] pos;
		logic             pos_valid;
		logic             line;
		logic             status;
	} reading_result_t;

	typedef enum {ROW_CONFIG, ROW_PREDICT, ROW_TYPED} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [3:0]       cfg;
		logic [1:0]       f;
		logic [3:0]       idx;
		logic [15:0]      raw;
		logic             last;
		logic [15:0]      w_norm;
		logic [POS_W-1:0] w_pos;
		logic             w_pv;
		logic             w_seen;
		logic             w_st;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [3:0]         cfg_data = 4'd0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         func = 2'd0;
	logic [3:0]         sensor_index = 4'd0;
	logic [15:0]        raw_value = 16'd0;
	logic               last_of_frame = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [15:0]        normalized_value;
	logic [POS_W-1:0]   position;
	logic               position_valid;
	logic               line_seen;
	logic               status;

	logic [3:0]         cfg_count = 4'd0;
	logic [15:0]        win_max [SENSORS_MAX] = '{default: 16'd0};
	logic [15:0]        win_min [SENSORS_MAX] = '{default: SAT16};
	logic               win_valid [SENSORS_MAX] = '{default: 1'b0};
	longint unsigned    centroid_num = 0;
	longint unsigned    centroid_den = 0;
	logic               frame_has_line = 1'b0;
	int unsigned        held_position = 0;

	reading_result_t    pending_readings [$];
	int                 idle_pct = 0;
	int                 stall_pct = 0;
	int                 stall_hold = 0;
	int                 cycle_count = 0;
	int                 mismatch_count = 0;
	int                 results_checked = 0;
	int                 readings_sent = 0;
	int                 useful_items = 0;
	int                 frames_closed = 0;
	int                 count_writes = 0;

	stim_row_t directed_rows [28] = '{
		'{ROW_TYPED,   4'd0,  FUNC_DETECT, 4'd0,  16'd300,   1'b1,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_ERR},
		'{ROW_TYPED,   4'd0,  FUNC_CAL,    4'd15, 16'd65535, 1'b1,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_ERR},
		'{ROW_CONFIG,  4'd10, FUNC_CLEAR,  4'd0,  16'd0,     1'b0,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_OK},
		'{ROW_TYPED,   4'd0,  FUNC_UNUSED, 4'd0,  16'd5,     1'b0,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_ERR},
		'{ROW_TYPED,   4'd0,  FUNC_DETECT, 4'd10, 16'd500,   1'b1,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_ERR},
		'{ROW_TYPED,   4'd0,  FUNC_DETECT, 4'd15, 16'd65535, 1'b1,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_ERR},
		'{ROW_TYPED,   4'd0,  FUNC_DETECT, 4'd3,  16'd65535, 1'b0,
			16'd65535, 14'd0,    1'b0, 1'b0, STATUS_OK},
		'{ROW_TYPED,   4'd0,  FUNC_DETECT, 4'd9,  16'd0,     1'b1,
			16'd0,     14'd3000, 1'b1, 1'b1, STATUS_OK},
		'{ROW_TYPED,   4'd0,  FUNC_CAL,    4'd0,  16'd100,   1'b0,
			16'd65535, 14'd3000, 1'b0, 1'b0, STATUS_OK},
		'{ROW_TYPED,   4'd0,  FUNC_CAL,    4'd0,  16'd1100,  1'b1,
			16'd1000,  14'd3000, 1'b0, 1'b0, STATUS_OK},
		'{ROW_TYPED,   4'd0,  FUNC_DETECT, 4'd0,  16'd50,    1'b0,
			16'd0,     14'd3000, 1'b0, 1'b0, STATUS_OK},
		'{ROW_PREDICT, 4'd0,  FUNC_DETECT, 4'd0,  16'd600,   1'b0,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_OK},
		'{ROW_PREDICT, 4'd0,  FUNC_CAL,    4'd1,  16'd0,     1'b0,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_OK},
		'{ROW_TYPED,   4'd0,  FUNC_CAL,    4'd1,  16'd65535, 1'b0,
			16'd1000,  14'd3000, 1'b0, 1'b0, STATUS_OK},
		'{ROW_PREDICT, 4'd0,  FUNC_DETECT, 4'd1,  16'd40000, 1'b0,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_OK},
		'{ROW_TYPED,   4'd0,  FUNC_CAL,    4'd4,  16'd0,     1'b0,
			16'd65535, 14'd3000, 1'b0, 1'b0, STATUS_OK},
		'{ROW_PREDICT, 4'd0,  FUNC_CAL,    4'd4,  16'd1,     1'b0,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_OK},
		'{ROW_PREDICT, 4'd0,  FUNC_DETECT, 4'd4,  16'd65535, 1'b1,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_OK},
		'{ROW_PREDICT, 4'd0,  FUNC_CLEAR,  4'd0,  16'd0,     1'b0,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_OK},
		'{ROW_PREDICT, 4'd0,  FUNC_DETECT, 4'd5,  16'd10,    1'b1,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_OK},
		'{ROW_PREDICT, 4'd0,  FUNC_DETECT, 4'd9,  16'd100,   1'b1,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_OK},
		'{ROW_CONFIG,  4'd1,  FUNC_CLEAR,  4'd0,  16'd0,     1'b0,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_OK},
		'{ROW_TYPED,   4'd0,  FUNC_DETECT, 4'd0,  16'd65535, 1'b1,
			16'd65535, 14'd0,    1'b1, 1'b1, STATUS_OK},
		'{ROW_TYPED,   4'd0,  FUNC_DETECT, 4'd1,  16'd65535, 1'b1,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_ERR},
		'{ROW_CONFIG,  4'd15, FUNC_CLEAR,  4'd0,  16'd0,     1'b0,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_OK},
		'{ROW_PREDICT, 4'd0,  FUNC_DETECT, 4'd9,  16'd1000,  1'b0,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_OK},
		'{ROW_PREDICT, 4'd0,  FUNC_DETECT, 4'd2,  16'd300,   1'b1,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_OK},
		'{ROW_PREDICT, 4'd0,  FUNC_CLEAR,  4'd7,  16'd12345, 1'b1,
			16'd0,     14'd0,    1'b0, 1'b0, STATUS_OK}
	};

	logic [3:0] phase_counts [12] = '{4'd10, 4'd7, 4'd15, 4'd1, 4'd0, 4'd4,
		4'd12, 4'd10, 4'd2, 4'd9, 4'd10, 4'd15};

	line_sensor_calibrate_position_top DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.sensor_index     (sensor_index),
		.raw_value        (raw_value),
		.last_of_frame    (last_of_frame),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.normalized_value (normalized_value),
		.position         (position),
		.position_valid   (position_valid),
		.line_seen        (line_seen),
		.status           (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d results outstanding",
				cycle_count, pending_readings.size());
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int unsigned sensors_in_use();
		return (cfg_count > SENSORS_MAX) ? SENSORS_MAX : cfg_count;
	endfunction

	function automatic logic [15:0] scale_reading(input logic [3:0] s, input logic [15:0] raw);
		longint unsigned q;
		if (!win_valid[s])
			return raw;
		if (raw < win_min[s])
			return 16'd0;
		if (win_max[s] <= win_min[s])
			return SAT16;
		q = (64'(raw - win_min[s]) * NORM_SCALE) / 64'(win_max[s] - win_min[s]);
		return (q > 64'(SAT16)) ? SAT16 : q[15:0];
	endfunction

	function automatic reading_result_t predict_reading(input logic [1:0] f,
		input logic [3:0] s, input logic [15:0] raw, input logic last);
		reading_result_t r;
		int unsigned     n;
		int unsigned     far;
		int              i;
		longint unsigned w;
		longint unsigned p;
		r = '0;
		n = sensors_in_use();
		if (n == 0 || f == FUNC_UNUSED) begin
			r.status = STATUS_ERR;
		end else if (f == FUNC_CLEAR) begin
			for (i = 0; i < n; i++) begin
				win_max[i] = 16'd0;
				win_min[i] = SAT16;
				win_valid[i] = 1'b0;
			end
		end else if (s >= n) begin
			r.status = STATUS_ERR;
		end else if (f == FUNC_CAL) begin
			if (win_max[s] < raw)
				win_max[s] = raw;
			if (win_min[s] > raw)
				win_min[s] = raw;
			win_valid[s] = 1'b1;
			r.norm = scale_reading(s, raw);
		end else begin
			far = 32'((n - 1) * NORM_SCALE);
			r.norm = scale_reading(s, raw);
			if (r.norm > LINE_LEVEL)
				frame_has_line = 1'b1;
			if (r.norm > WEIGHT_LEVEL) begin
				w = 64'(s) * NORM_SCALE * 64'(r.norm);
				centroid_num = (w > WSUM_LIMIT - centroid_num) ? WSUM_LIMIT : centroid_num + w;
				centroid_den = (centroid_den + r.norm > VSUM_LIMIT) ? VSUM_LIMIT :
					centroid_den + r.norm;
			end
			if (last) begin
				if (frame_has_line && centroid_den != 0) begin
					p = centroid_num / centroid_den;
					held_position = (p > far) ? far : 32'(p);
				end else if (held_position < far / 2) begin
					held_position = 0;
				end else begin
					held_position = far;
				end
				r.pos_valid = 1'b1;
				r.line = frame_has_line;
				centroid_num = 0;
				centroid_den = 0;
				frame_has_line = 1'b0;
			end
		end
		r.pos = POS_W'(held_position);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
		input longint unsigned want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("result %0d at cycle %0d: %s is %0d, expected %0d",
				results_checked, cycle_count, what, got, want);
	endtask

	task automatic send_reading(input logic [1:0] f, input logic [3:0] s,
		input logic [15:0] raw, input logic last, input bit use_typed,
		input reading_result_t typed);
		int              gap;
		reading_result_t want;
		gap = 0;
		if ($urandom_range(99) < idle_pct)
			gap = $urandom_range(1, 90);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		sensor_index <= s;
		raw_value <= raw;
		last_of_frame <= last;
		do @(posedge clk); while (in_stall);
		want = predict_reading(f, s, raw, last);
		readings_sent++;
		if (want.status == STATUS_OK)
			useful_items++;
		if (want.pos_valid)
			frames_closed++;
		if (use_typed)
			want = typed;
		pending_readings.push_back(want);
	endtask

	task automatic drive_reading(input logic [1:0] f, input logic [3:0] s,
		input logic [15:0] raw, input logic last);
		send_reading(f, s, raw, last, 1'b0, '0);
	endtask

	task automatic write_sensor_count(input logic [3:0] value);
		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_count = value;
		count_writes++;
	endtask

	task automatic noise_reading();
		drive_reading(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
			16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
	endtask

	task automatic calibrate_sensors(input int unsigned n);
		int unsigned s;
		int unsigned lo;
		int unsigned hi;
		int          extra;
		drive_reading(FUNC_CLEAR, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
			1'($urandom_range(0, 1)));
		for (s = 0; s < n; s++) begin
			if ($urandom_range(9) != 0) begin
				lo = $urandom_range(0, 1500);
				hi = lo + $urandom_range(0, 2500);
				drive_reading(FUNC_CAL, 4'(s), 16'(lo), 1'($urandom_range(0, 1)));
				drive_reading(FUNC_CAL, 4'(s), 16'(hi), 1'($urandom_range(0, 1)));
				extra = $urandom_range(0, 2);
				repeat (extra)
					drive_reading(FUNC_CAL, 4'(s), 16'($urandom_range(lo, hi)), 1'b0);
			end
		end
	endtask

	task automatic detect_frame(input int unsigned n, input bit dark);
		int unsigned s;
		logic [15:0] raw;
		for (s = 0; s < n; s++) begin
			if (dark)
				raw = 16'($urandom_range(0, 40));
			else if ($urandom_range(19) == 0)
				raw = 16'($urandom_range(0, 65535));
			else
				raw = 16'($urandom_range(0, 4500));
			drive_reading(FUNC_DETECT, 4'(s), raw, s == n - 1);
		end
	endtask

	task automatic bright_frame(input int unsigned n);
		int len;
		int k;
		len = $urandom_range(12, 24);
		for (k = 0; k < len; k++)
			drive_reading(FUNC_DETECT, 4'($urandom_range(0, n - 1)),
				16'($urandom_range(60000, 65535)), k == len - 1);
	endtask

	task automatic run_phase(input logic [3:0] value, input int mode);
		int unsigned n;
		int          start;
		int          pick;
		case (mode)
			0: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct = 66;
				stall_pct = 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct = 66;
			end
			default: begin
				idle_pct = 17;
				stall_pct = 17;
			end
		endcase
		write_sensor_count(value);
		n = sensors_in_use();
		if (n == 0) begin
			repeat (30) noise_reading();
			return;
		end
		start = useful_items;
		if ($urandom_range(9) < 8)
			calibrate_sensors(n);
		while (useful_items - start < PHASE_QUOTA) begin
			pick = $urandom_range(99);
			if (pick < 70)
				detect_frame(n, 1'b0);
			else if (pick < 78)
				detect_frame(n, 1'b1);
			else if (pick < 86)
				bright_frame(n);
			else if (pick < 92)
				calibrate_sensors(n);
			else
				noise_reading();
		end
	endtask

	initial begin
		reading_result_t got;
		reading_result_t want;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && !out_stall) begin
				got = '{normalized_value, position, position_valid, line_seen, status};
				results_checked++;
				if (pending_readings.size() == 0) begin
					report_mismatch("transaction with nothing expected", 1, 0);
				end else begin
					want = pending_readings.pop_front();
					if (got.norm !== want.norm)
						report_mismatch("normalized_value", got.norm, want.norm);
					if (got.pos !== want.pos)
						report_mismatch("position", got.pos, want.pos);
					if (got.pos_valid !== want.pos_valid)
						report_mismatch("position_valid", got.pos_valid, want.pos_valid);
					if (got.line !== want.line)
						report_mismatch("line_seen", got.line, want.line);
					if (got.status !== want.status)
						report_mismatch("status", got.status, want.status);
				end
			end
			if (stall_hold > 0) begin
				stall_hold--;
				out_stall <= 1'b1;
			end else if (stall_pct > 0 && $urandom_range(199) == 0) begin
				stall_hold = $urandom_range(20, 60);
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	initial begin
		stim_row_t r;
		int        k;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (k = 0; k < 28; k++) begin
			r = directed_rows[k];
			if (r.kind == ROW_CONFIG)
				write_sensor_count(r.cfg);
			else
				send_reading(r.f, r.idx, r.raw, r.last, r.kind == ROW_TYPED,
					'{r.w_norm, r.w_pos, r.w_pv, r.w_seen, r.w_st});
		end
		for (k = 0; k < 12; k++)
			run_phase(phase_counts[k], k % 4);
		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
		$display("%0d readings sent under %0d sensor count writes, %0d frames closed",
			readings_sent, count_writes, frames_closed);
		$display("%0d results compared, %0d mismatches", results_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
